// ----- hw/rtl/ks2kc_pkg.sv -----
// ks2kc_pkg: shared types, codes and helpers for the keysym to keycode sequencer
// no dependencies; used by every module of the block but ks2kc_ram
`default_nettype none

package ks2kc_pkg;

    localparam int COLUMNS = 4;
    localparam int KS_W    = 29;
    localparam int SLOTS   = 14;

    // result direction codes
    localparam logic [1:0] DIR_PRESS   = 2'd0;
    localparam logic [1:0] DIR_RELEASE = 2'd1;
    localparam logic [1:0] DIR_TAP     = 2'd2;

    // result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_ASSIGNED = 2'd1;
    localparam logic [1:0] ST_NOFREE   = 2'd2;
    localparam logic [1:0] ST_WRITE    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_FIRST_KEYCODE    = 3'd0;
    localparam logic [2:0] REG_ROWS_IN_USE      = 3'd1;
    localparam logic [2:0] REG_SHIFT_KEY        = 3'd2;
    localparam logic [2:0] REG_MODE_SWITCH_KEY  = 3'd3;
    localparam logic [2:0] REG_CONTROL_KEY      = 3'd4;
    localparam logic [2:0] REG_META_KEY         = 3'd5;
    localparam logic [2:0] REG_ALT_KEY          = 3'd6;
    localparam logic [2:0] REG_STICKY_SHIFT_KEY = 3'd7;

    typedef struct packed {
        logic            opcode;
        logic [7:0]      row;
        logic [1:0]      column;
        logic [KS_W-1:0] keysym;
        logic            control_mode;
        logic            meta_mode;
        logic            alt_mode;
        logic            shift_mode;
    } req_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic [1:0] direction;
        logic [1:0] status;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [7:0] first_keycode;
        logic [8:0] rows_in_use;
        logic [7:0] shift_key;
        logic [7:0] mode_switch_key;
        logic [7:0] control_key;
        logic [7:0] meta_key;
        logic [7:0] alt_key;
        logic [7:0] sticky_shift_key;
    } cfg_t;

    typedef enum logic {
        CMD_LOAD,
        CMD_TRANSLATE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic            write_ok;
        logic [7:0]      row;
        logic [1:0]      column;
        logic [KS_W-1:0] keysym;
        logic            control_mode;
        logic            meta_mode;
        logic            alt_mode;
        logic            shift_mode;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DECIDE,
        BK_EMIT
    } back_state_t;

    function automatic logic is_modifier_sym(input logic [KS_W-1:0] ks);
        logic hit;
        begin
            hit = ((ks >= 29'h0FFE1) && (ks <= 29'h0FFEE)) ||
                  ((ks >= 29'h0FE01) && (ks <= 29'h0FE13)) ||
                  (ks == 29'h0FF7E) || (ks == 29'h0FF7F);
            return hit;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/keysym_to_keycode_sequencer_unit.sv -----
// keysym_to_keycode_sequencer_unit: top level of the keysym to keycode sequencer
// depends on ks2kc_pkg, ks2kc_regs, ks2kc_front, ks2kc_back (with ks2kc_ram)
//
//  channel   signals                                   transfer when
//  request   req_valid, req_ready, req                 req_valid && req_ready
//  result    rsp_valid, rsp_ready, rsp                 rsp_valid && rsp_ready
//  config    psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//            prdata, pready
//
// a load goes from the queue head through the idle and emit states into the result register
// a translate reads one keymap entry a cycle through the single ram read port:
//   at most 4 * min(rows_in_use, MAX_ROWS) entries, then up to 13 events in slot order
// a two-entry queue lets requests arrive while the back end is busy
// the result register holds under back-pressure; the keymap has no reset and no clearing pass
`default_nettype none

module keysym_to_keycode_sequencer_unit #(
    parameter int MAX_ROWS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire ks2kc_pkg::req_t   req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output ks2kc_pkg::rsp_t        rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    ks2kc_pkg::cfg_t cfg;
    ks2kc_pkg::cmd_t q_cmd;
    logic            q_valid;
    logic            q_pop;

    ks2kc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ks2kc_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd)
    );

    ks2kc_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ks2kc_ram.sv -----
// ks2kc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ks2kc_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ks2kc_regs.sv -----
// ks2kc_regs: apb-style configuration registers of the sequencer
// depends on ks2kc_pkg
`default_nettype none

module ks2kc_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output ks2kc_pkg::cfg_t        cfg
);

    ks2kc_pkg::cfg_t cfg_reg;
    ks2kc_pkg::cfg_t cfg_next;
    logic [2:0]      index;
    logic            wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                ks2kc_pkg::REG_FIRST_KEYCODE:    cfg_next.first_keycode    = pwdata[7:0];
                ks2kc_pkg::REG_ROWS_IN_USE:      cfg_next.rows_in_use      = pwdata[8:0];
                ks2kc_pkg::REG_SHIFT_KEY:        cfg_next.shift_key        = pwdata[7:0];
                ks2kc_pkg::REG_MODE_SWITCH_KEY:  cfg_next.mode_switch_key  = pwdata[7:0];
                ks2kc_pkg::REG_CONTROL_KEY:      cfg_next.control_key      = pwdata[7:0];
                ks2kc_pkg::REG_META_KEY:         cfg_next.meta_key         = pwdata[7:0];
                ks2kc_pkg::REG_ALT_KEY:          cfg_next.alt_key          = pwdata[7:0];
                ks2kc_pkg::REG_STICKY_SHIFT_KEY: cfg_next.sticky_shift_key = pwdata[7:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            ks2kc_pkg::REG_FIRST_KEYCODE:    prdata = {24'd0, cfg_reg.first_keycode};
            ks2kc_pkg::REG_ROWS_IN_USE:      prdata = {23'd0, cfg_reg.rows_in_use};
            ks2kc_pkg::REG_SHIFT_KEY:        prdata = {24'd0, cfg_reg.shift_key};
            ks2kc_pkg::REG_MODE_SWITCH_KEY:  prdata = {24'd0, cfg_reg.mode_switch_key};
            ks2kc_pkg::REG_CONTROL_KEY:      prdata = {24'd0, cfg_reg.control_key};
            ks2kc_pkg::REG_META_KEY:         prdata = {24'd0, cfg_reg.meta_key};
            ks2kc_pkg::REG_ALT_KEY:          prdata = {24'd0, cfg_reg.alt_key};
            ks2kc_pkg::REG_STICKY_SHIFT_KEY: prdata = {24'd0, cfg_reg.sticky_shift_key};
            default:                         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_keycode    <= 8'd8;
            cfg_reg.rows_in_use      <= 9'd248;
            cfg_reg.shift_key        <= 8'd50;
            cfg_reg.mode_switch_key  <= 8'd0;
            cfg_reg.control_key      <= 8'd37;
            cfg_reg.meta_key         <= 8'd0;
            cfg_reg.alt_key          <= 8'd0;
            cfg_reg.sticky_shift_key <= 8'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ks2kc_front.sv -----
// ks2kc_front: accepts request transfers, classifies them and queues them for the back end
// depends on ks2kc_pkg
`default_nettype none

module ks2kc_front #(
    parameter int MAX_ROWS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire ks2kc_pkg::req_t   req,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output ks2kc_pkg::cmd_t        q_cmd
);

    ks2kc_pkg::cmd_t fifo_reg [2];
    ks2kc_pkg::cmd_t cmd_in;
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign req_ready = (count_reg != 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_cmd     = fifo_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_pop && q_valid;

    // classify: decode the opcode and check the row against the keymap depth
    always_comb
    begin
        cmd_in.kind         = req.opcode ? ks2kc_pkg::CMD_TRANSLATE : ks2kc_pkg::CMD_LOAD;
        cmd_in.write_ok     = ({1'b0, req.row} < 9'(MAX_ROWS));
        cmd_in.row          = req.row;
        cmd_in.column       = req.column;
        cmd_in.keysym       = req.keysym;
        cmd_in.control_mode = req.control_mode;
        cmd_in.meta_mode    = req.meta_mode;
        cmd_in.alt_mode     = req.alt_mode;
        cmd_in.shift_mode   = req.shift_mode;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ks2kc_back.sv -----
// ks2kc_back: keymap store, scan for translates and key event sequencing
// depends on ks2kc_pkg and ks2kc_ram
`default_nettype none

module ks2kc_back #(
    parameter int MAX_ROWS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ks2kc_pkg::cfg_t   cfg,
    input  wire logic              q_valid,
    input  wire ks2kc_pkg::cmd_t   q_cmd,
    output logic                   q_pop,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output ks2kc_pkg::rsp_t        rsp
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = RW + 2;
    localparam int DEPTH = MAX_ROWS * ks2kc_pkg::COLUMNS;
    localparam int KW    = ks2kc_pkg::KS_W;
    localparam int SW    = ks2kc_pkg::SLOTS;

    // event slots in emission order
    localparam logic [3:0] SL_CTRL_P   = 4'd0;
    localparam logic [3:0] SL_META_P   = 4'd1;
    localparam logic [3:0] SL_ALT_P    = 4'd2;
    localparam logic [3:0] SL_STICKY_P = 4'd3;
    localparam logic [3:0] SL_SHIFT_P  = 4'd4;
    localparam logic [3:0] SL_MODE_P   = 4'd5;
    localparam logic [3:0] SL_KEY      = 4'd6;
    localparam logic [3:0] SL_MODE_R   = 4'd7;
    localparam logic [3:0] SL_SHIFT_R  = 4'd8;
    localparam logic [3:0] SL_CTRL_R   = 4'd9;
    localparam logic [3:0] SL_META_R   = 4'd10;
    localparam logic [3:0] SL_ALT_R    = 4'd11;
    localparam logic [3:0] SL_STICKY_R = 4'd12;
    localparam logic [3:0] SL_BARE     = 4'd13;

    ks2kc_pkg::back_state_t state_reg;
    ks2kc_pkg::back_state_t state_next;

    logic [AW:0]     addr_reg;
    logic [AW:0]     addr_next;
    logic [AW-1:0]   pa_reg;
    logic [AW-1:0]   pa_next;
    logic            rd_valid_reg;
    logic            rd_valid_next;
    logic            row_ok_reg;
    logic            row_ok_next;
    logic            found_reg;
    logic            found_next;
    logic            have_free_reg;
    logic            have_free_next;
    logic [AW-1:0]   hit_reg;
    logic [AW-1:0]   hit_next;
    logic [AW-1:0]   free_reg;
    logic [AW-1:0]   free_next;
    logic [KW-1:0]   ks_reg;
    logic [KW-1:0]   ks_next;
    logic [3:0]      modes_reg;
    logic [3:0]      modes_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic [SW-1:0]   pending_reg;
    logic [SW-1:0]   pending_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    ks2kc_pkg::rsp_t rsp_reg;
    ks2kc_pkg::rsp_t rsp_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [KW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [KW-1:0]   ram_rdata;

    logic [RW:0]     rows_sat;
    logic [AW:0]     limit;
    logic            eval;
    logic            row_ok_eff;
    logic            hit_now;
    logic            free_now;
    logic            scan_done;
    logic            issue;
    logic [3:0]      sel;
    logic [SW-1:0]   rest;
    logic            out_load;
    logic [7:0]      key;
    logic [1:0]      dcol;

    ks2kc_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_keymap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rows_sat = (cfg.rows_in_use > 9'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS)
                                                       : (RW+1)'(cfg.rows_in_use);
    assign limit    = {rows_sat, 2'b00};

    // scan compare on the entry whose read data has just come back
    assign eval       = (state_reg == ks2kc_pkg::BK_SCAN) && rd_valid_reg;
    assign row_ok_eff = (pa_reg[1:0] == 2'd0) ? !ks2kc_pkg::is_modifier_sym(ram_rdata)
                                              : row_ok_reg;
    assign hit_now    = eval && (ram_rdata == ks_reg);
    assign free_now   = eval && !hit_now && !have_free_reg && row_ok_eff
                        && (ram_rdata == '0);
    assign scan_done  = !rd_valid_reg && (addr_reg >= limit);
    assign issue      = (state_reg == ks2kc_pkg::BK_SCAN) && (addr_reg < limit) && !hit_now;
    assign ram_raddr  = addr_reg[AW-1:0];

    // lowest pending slot goes out first
    always_comb
    begin
        sel = SL_BARE;
        for (int i = SW - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                sel = 4'(i);
            end
        end
    end

    assign rest     = pending_reg & ~(SW'(1) << sel);
    assign out_load = (state_reg == ks2kc_pkg::BK_EMIT) && (!rsp_valid_reg || rsp_ready);
    assign key      = cfg.first_keycode + 8'(hit_reg[AW-1:2]);
    assign dcol     = found_reg ? hit_reg[1:0] : free_reg[1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ks2kc_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_cmd.kind == ks2kc_pkg::CMD_LOAD) ? ks2kc_pkg::BK_EMIT
                                                                     : ks2kc_pkg::BK_SCAN;
                end
            end
            ks2kc_pkg::BK_SCAN:
            begin
                if (hit_now || scan_done)
                begin
                    state_next = ks2kc_pkg::BK_DECIDE;
                end
            end
            ks2kc_pkg::BK_DECIDE:
            begin
                state_next = ks2kc_pkg::BK_EMIT;
            end
            ks2kc_pkg::BK_EMIT:
            begin
                if (out_load && (rest == '0))
                begin
                    state_next = ks2kc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ks2kc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = free_reg;
        ram_wdata      = ks_reg;
        addr_next      = addr_reg;
        pa_next        = pa_reg;
        rd_valid_next  = 1'b0;
        row_ok_next    = row_ok_reg;
        found_next     = found_reg;
        have_free_next = have_free_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        ks_next        = ks_reg;
        modes_next     = modes_reg;
        status_next    = status_reg;
        pending_next   = pending_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ks2kc_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    ks_next        = q_cmd.keysym;
                    modes_next     = {q_cmd.shift_mode, q_cmd.alt_mode,
                                      q_cmd.meta_mode, q_cmd.control_mode};
                    addr_next      = '0;
                    found_next     = 1'b0;
                    have_free_next = 1'b0;
                    if (q_cmd.kind == ks2kc_pkg::CMD_LOAD)
                    begin
                        ram_we       = q_cmd.write_ok;
                        ram_waddr    = {q_cmd.row[RW-1:0], q_cmd.column};
                        ram_wdata    = q_cmd.keysym;
                        status_next  = ks2kc_pkg::ST_WRITE;
                        pending_next = SW'(1) << SL_BARE;
                    end
                end
            end
            ks2kc_pkg::BK_SCAN:
            begin
                if (eval && (pa_reg[1:0] == 2'd0))
                begin
                    row_ok_next = row_ok_eff;
                end
                if (hit_now)
                begin
                    found_next = 1'b1;
                    hit_next   = pa_reg;
                end
                if (free_now)
                begin
                    have_free_next = 1'b1;
                    free_next      = pa_reg;
                end
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                    pa_next       = addr_reg[AW-1:0];
                    addr_next     = addr_reg + (AW+1)'(1);
                end
            end
            ks2kc_pkg::BK_DECIDE:
            begin
                if (found_reg)
                begin
                    status_next = ks2kc_pkg::ST_FOUND;
                end
                else if (have_free_reg)
                begin
                    // claim the first free entry for this keysym
                    ram_we      = 1'b1;
                    hit_next    = free_reg;
                    status_next = ks2kc_pkg::ST_ASSIGNED;
                end
                else
                begin
                    status_next = ks2kc_pkg::ST_NOFREE;
                end
                if (found_reg || have_free_reg)
                begin
                    pending_next              = '0;
                    pending_next[SL_CTRL_P]   = modes_reg[0];
                    pending_next[SL_META_P]   = modes_reg[1];
                    pending_next[SL_ALT_P]    = modes_reg[2];
                    pending_next[SL_STICKY_P] = modes_reg[3];
                    pending_next[SL_SHIFT_P]  = dcol[0];
                    pending_next[SL_MODE_P]   = dcol[1];
                    pending_next[SL_KEY]      = 1'b1;
                    pending_next[SL_MODE_R]   = dcol[1];
                    pending_next[SL_SHIFT_R]  = dcol[0];
                    pending_next[SL_CTRL_R]   = modes_reg[0];
                    pending_next[SL_META_R]   = modes_reg[1];
                    pending_next[SL_ALT_R]    = modes_reg[2];
                    pending_next[SL_STICKY_R] = modes_reg[3];
                end
                else
                begin
                    pending_next = SW'(1) << SL_BARE;
                end
            end
            ks2kc_pkg::BK_EMIT:
            begin
                if (out_load)
                begin
                    pending_next       = rest;
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = status_reg;
                    rsp_next.last      = (rest == '0);
                    rsp_next.direction = ks2kc_pkg::DIR_PRESS;
                    case (sel)
                        SL_CTRL_P:   rsp_next.key_code = cfg.control_key;
                        SL_META_P:   rsp_next.key_code = cfg.meta_key;
                        SL_ALT_P:    rsp_next.key_code = cfg.alt_key;
                        SL_STICKY_P: rsp_next.key_code = cfg.sticky_shift_key;
                        SL_SHIFT_P:  rsp_next.key_code = cfg.shift_key;
                        SL_MODE_P:   rsp_next.key_code = cfg.mode_switch_key;
                        SL_KEY:
                        begin
                            rsp_next.key_code  = key;
                            rsp_next.direction = ks2kc_pkg::DIR_TAP;
                        end
                        SL_MODE_R:
                        begin
                            rsp_next.key_code  = cfg.mode_switch_key;
                            rsp_next.direction = ks2kc_pkg::DIR_RELEASE;
                        end
                        SL_SHIFT_R:
                        begin
                            rsp_next.key_code  = cfg.shift_key;
                            rsp_next.direction = ks2kc_pkg::DIR_RELEASE;
                        end
                        SL_CTRL_R:
                        begin
                            rsp_next.key_code  = cfg.control_key;
                            rsp_next.direction = ks2kc_pkg::DIR_RELEASE;
                        end
                        SL_META_R:
                        begin
                            rsp_next.key_code  = cfg.meta_key;
                            rsp_next.direction = ks2kc_pkg::DIR_RELEASE;
                        end
                        SL_ALT_R:
                        begin
                            rsp_next.key_code  = cfg.alt_key;
                            rsp_next.direction = ks2kc_pkg::DIR_RELEASE;
                        end
                        SL_STICKY_R:
                        begin
                            rsp_next.key_code  = cfg.sticky_shift_key;
                            rsp_next.direction = ks2kc_pkg::DIR_RELEASE;
                        end
                        default:     rsp_next.key_code = 8'd0;
                    endcase
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ks2kc_pkg::BK_IDLE;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            pending_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            have_free_reg <= have_free_next;
            pending_reg   <= pending_next;
            rsp_valid_reg <= rsp_valid_next;
            addr_reg      <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg     <= pa_next;
        row_ok_reg <= row_ok_next;
        hit_reg    <= hit_next;
        free_reg   <= free_next;
        ks_reg     <= ks_next;
        modes_reg  <= modes_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ks2kc_pkg::BK_IDLE || state_reg == ks2kc_pkg::BK_DECIDE))
        else $error("keymap written outside load or assign");

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ks2kc_pkg::BK_EMIT) |-> (pending_reg != '0))
        else $error("emitting with no event left");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (rest == '0)) |=> (state_reg == ks2kc_pkg::BK_IDLE && rsp_reg.last))
        else $error("final event did not end the item");

    a_read_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ks2kc_pkg::BK_SCAN && addr_reg <= limit))
        else $error("keymap read in flight outside the scan");

endmodule

`default_nettype wire
